// ===== rtl/rmq_pkg.sv =====
// Shared types for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic valid;
    logic stall;
  } hs_t;

endpackage

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on rmq_pkg for the handshake struct.
module rmq_sqrt #(
  parameter int XW    = 44,
  parameter int TAG_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmq_pkg::hs_t        up_hs_i,
  output logic                up_stall_o,
  input  logic [XW-1:0]       x_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic                dn_valid_o,
  input  logic                dn_stall_i,
  output logic [XW/2-1:0]     root_o,
  output logic [TAG_W-1:0]    tag_o
);
  import rmq_pkg::*;

  localparam int RW  = XW / 2;
  localparam int RMW = RW + 2;

  logic              v_r    [RW];
  logic [RMW-1:0]    rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [XW-1:0]     x_r    [RW];
  logic [TAG_W-1:0]  tag_r  [RW];

  logic              ld     [RW];
  logic              p_v    [RW];
  logic [RMW-1:0]    p_rem  [RW];
  logic [RW-1:0]     p_root [RW];
  logic [XW-1:0]     p_x    [RW];
  logic [TAG_W-1:0]  p_tag  [RW];
  logic [RMW-1:0]    rem_nxt  [RW];
  logic [RW-1:0]     root_nxt [RW];
  logic [XW-1:0]     x_nxt    [RW];

  // a stage loads when empty or when its content moves on
  always_comb begin
    for (int i = RW - 1; i >= 0; i--) begin
      if (i == RW - 1) begin
        ld[i] = !v_r[i] || !dn_stall_i;
      end else begin
        ld[i] = !v_r[i] || ld[i+1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < RW; g++) begin : g_stage
      logic [RMW-1:0] rs;
      logic [RMW-1:0] t;
      if (g == 0) begin : g_first
        assign p_v[g]    = up_hs_i.valid;
        assign p_rem[g]  = '0;
        assign p_root[g] = '0;
        assign p_x[g]    = x_i;
        assign p_tag[g]  = tag_i;
      end else begin : g_rest
        assign p_v[g]    = v_r[g-1];
        assign p_rem[g]  = rem_r[g-1];
        assign p_root[g] = root_r[g-1];
        assign p_x[g]    = x_r[g-1];
        assign p_tag[g]  = tag_r[g-1];
      end
      always_comb begin
        rs = {p_rem[g][RMW-3:0], p_x[g][XW-1:XW-2]};
        t  = {p_root[g], 2'b01};
        x_nxt[g] = {p_x[g][XW-3:0], 2'b00};
        if (rs >= t) begin
          rem_nxt[g]  = rs - t;
          root_nxt[g] = {p_root[g][RW-2:0], 1'b1};
        end else begin
          rem_nxt[g]  = rs;
          root_nxt[g] = {p_root[g][RW-2:0], 1'b0};
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (ld[g]) begin
          v_r[g] <= p_v[g];
        end
      end
      always_ff @(posedge clk) begin
        if (ld[g]) begin
          rem_r[g]  <= rem_nxt[g];
          root_r[g] <= root_nxt[g];
          x_r[g]    <= x_nxt[g];
          tag_r[g]  <= p_tag[g];
        end
      end
    end
  endgenerate

  assign up_stall_o = !ld[0];
  assign dn_valid_o = v_r[RW-1];
  assign root_o     = root_r[RW-1];
  assign tag_o      = tag_r[RW-1];

endmodule

// ===== rtl/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Depends on rmq_pkg for the handshake struct.
module rmq_div #(
  parameter int NW    = 32,
  parameter int DW    = 16,
  parameter int LANES = 3,
  parameter int TAG_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rmq_pkg::hs_t                up_hs_i,
  output logic                        up_stall_o,
  input  logic [LANES-1:0][NW-1:0]    n_i,
  input  logic [DW-1:0]               d_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        dn_valid_o,
  input  logic                        dn_stall_i,
  output logic [LANES-1:0][NW-1:0]    q_o,
  output logic [TAG_W-1:0]            tag_o
);
  import rmq_pkg::*;

  logic                      v_r   [NW];
  logic [LANES-1:0][NW-1:0]  n_r   [NW];
  logic [LANES-1:0][DW-1:0]  rem_r [NW];
  logic [LANES-1:0][NW-1:0]  q_r   [NW];
  logic [DW-1:0]             d_r   [NW];
  logic [TAG_W-1:0]          tag_r [NW];

  logic                      ld    [NW];
  logic                      p_v   [NW];
  logic [LANES-1:0][NW-1:0]  p_n   [NW];
  logic [LANES-1:0][DW-1:0]  p_rem [NW];
  logic [LANES-1:0][NW-1:0]  p_q   [NW];
  logic [DW-1:0]             p_d   [NW];
  logic [TAG_W-1:0]          p_tag [NW];
  logic [LANES-1:0][NW-1:0]  n_nxt   [NW];
  logic [LANES-1:0][DW-1:0]  rem_nxt [NW];
  logic [LANES-1:0][NW-1:0]  q_nxt   [NW];

  always_comb begin
    for (int i = NW - 1; i >= 0; i--) begin
      if (i == NW - 1) begin
        ld[i] = !v_r[i] || !dn_stall_i;
      end else begin
        ld[i] = !v_r[i] || ld[i+1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < NW; g++) begin : g_stage
      logic [DW:0] rs;
      if (g == 0) begin : g_first
        assign p_v[g]   = up_hs_i.valid;
        assign p_n[g]   = n_i;
        assign p_rem[g] = '0;
        assign p_q[g]   = '0;
        assign p_d[g]   = d_i;
        assign p_tag[g] = tag_i;
      end else begin : g_rest
        assign p_v[g]   = v_r[g-1];
        assign p_n[g]   = n_r[g-1];
        assign p_rem[g] = rem_r[g-1];
        assign p_q[g]   = q_r[g-1];
        assign p_d[g]   = d_r[g-1];
        assign p_tag[g] = tag_r[g-1];
      end
      always_comb begin
        rs = '0;
        for (int l = 0; l < LANES; l++) begin
          rs = {p_rem[g][l], p_n[g][l][NW-1]};
          n_nxt[g][l] = {p_n[g][l][NW-2:0], 1'b0};
          if (rs >= {1'b0, p_d[g]}) begin
            rem_nxt[g][l] = DW'(rs - {1'b0, p_d[g]});
            q_nxt[g][l]   = {p_q[g][l][NW-2:0], 1'b1};
          end else begin
            rem_nxt[g][l] = rs[DW-1:0];
            q_nxt[g][l]   = {p_q[g][l][NW-2:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (ld[g]) begin
          v_r[g] <= p_v[g];
        end
      end
      always_ff @(posedge clk) begin
        if (ld[g]) begin
          n_r[g]   <= n_nxt[g];
          rem_r[g] <= rem_nxt[g];
          q_r[g]   <= q_nxt[g];
          d_r[g]   <= p_d[g];
          tag_r[g] <= p_tag[g];
        end
      end
    end
  endgenerate

  assign up_stall_o = !ld[0];
  assign dn_valid_o = v_r[NW-1];
  assign q_o        = q_r[NW-1];
  assign tag_o      = tag_r[NW-1];

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion, Shepperd's method in fixed point.
// Stages: input register, RW square-root stages, middle register, NW
// divider stages, output register. Throughput: one transfer per cycle
// when not stalled. Every stage holds under stall and bubbles collapse.
// Reset (synchronous, active low) clears all stage valid bits.
// Depends on rmq_pkg, rmq_sqrt, rmq_div.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS  = 14,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ELEM_WIDTH-1:0] in_m00,
  input  logic signed [ELEM_WIDTH-1:0] in_m01,
  input  logic signed [ELEM_WIDTH-1:0] in_m02,
  input  logic signed [ELEM_WIDTH-1:0] in_m10,
  input  logic signed [ELEM_WIDTH-1:0] in_m11,
  input  logic signed [ELEM_WIDTH-1:0] in_m12,
  input  logic signed [ELEM_WIDTH-1:0] in_m20,
  input  logic signed [ELEM_WIDTH-1:0] in_m21,
  input  logic signed [ELEM_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ELEM_WIDTH-1:0] out_quat_w,
  output logic signed [ELEM_WIDTH-1:0] out_quat_x,
  output logic signed [ELEM_WIDTH-1:0] out_quat_y,
  output logic signed [ELEM_WIDTH-1:0] out_quat_z,
  output rmq_pkg::branch_t             out_branch_taken,
  output logic                         out_fault
);
  import rmq_pkg::*;

  localparam int W     = ELEM_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int AW    = ((W > F) ? W : F) + 3;
  localparam int AUW   = AW - 1;
  localparam int XW0   = AUW + F;
  localparam int XW    = XW0 + (XW0 % 2);
  localparam int RW    = XW / 2;
  localparam int NS    = W + 1;
  localparam int NW    = (((W + 1 + F) > RW) ? (W + 1 + F) : RW) + 1;
  localparam int DW    = RW + 1;
  localparam int CW    = ((RW + 1) > W) ? (RW + 1) : W;
  localparam int TAG1  = 3 * NS + 3;
  localparam int TAG2  = W + 10;
  localparam logic [W-1:0]  EMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  EMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [AW-1:0] ONE_A = {{(AW-1){1'b0}}, 1'b1} << F;

  // ---------------- front: branch, root argument, numerators
  logic signed [AW-1:0] e00, e11, e22, trace, arg;
  logic signed [NS-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  logic signed [NS-1:0] fn0, fn1, fn2;
  branch_t              fbr;
  logic                 fflt;
  logic [AUW-1:0]       a_u;

  always_comb begin
    e00 = AW'(in_m00);
    e11 = AW'(in_m11);
    e22 = AW'(in_m22);
    trace = e00 + e11 + e22;
    d21_12 = NS'(in_m21) - NS'(in_m12);
    d02_20 = NS'(in_m02) - NS'(in_m20);
    d10_01 = NS'(in_m10) - NS'(in_m01);
    s01_10 = NS'(in_m01) + NS'(in_m10);
    s02_20 = NS'(in_m02) + NS'(in_m20);
    s12_21 = NS'(in_m12) + NS'(in_m21);
    if (!trace[AW-1] && (trace != '0)) begin
      fbr = BR_TRACE;
      arg = ONE_A + trace;
      fn0 = d21_12; fn1 = d02_20; fn2 = d10_01;
    end else if ((e00 > e11) && (e00 > e22)) begin
      fbr = BR_X;
      arg = ONE_A + e00 - e11 - e22;
      fn0 = d21_12; fn1 = s01_10; fn2 = s02_20;
    end else if (e11 > e22) begin
      fbr = BR_Y;
      arg = ONE_A + e11 - e00 - e22;
      fn0 = d02_20; fn1 = s01_10; fn2 = s12_21;
    end else begin
      fbr = BR_Z;
      arg = ONE_A + e22 - e00 - e11;
      fn0 = d10_01; fn1 = s02_20; fn2 = s12_21;
    end
    // clamp a negative root argument
    fflt = arg[AW-1];
    a_u  = fflt ? '0 : arg[AUW-1:0];
  end

  logic             s0_v_r;
  logic [XW-1:0]    s0_x_r;
  logic [TAG1-1:0]  s0_tag_r;
  logic             s0_ld;
  logic             sq_up_stall;

  assign s0_ld    = !s0_v_r || !sq_up_stall;
  assign in_stall = !s0_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_ld) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ld) begin
      s0_x_r   <= XW'(a_u) << F;
      s0_tag_r <= {fn2, fn1, fn0, fbr, fflt};
    end
  end

  // ---------------- square root
  hs_t             sq_hs;
  logic            sq_dn_valid;
  logic            sm_ld;
  logic [RW-1:0]   sq_root;
  logic [TAG1-1:0] sq_tag;

  assign sq_hs.valid = s0_v_r;
  assign sq_hs.stall = 1'b0;

  rmq_sqrt #(.XW(XW), .TAG_W(TAG1)) u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_hs_i    (sq_hs),
    .up_stall_o (sq_up_stall),
    .x_i        (s0_x_r),
    .tag_i      (s0_tag_r),
    .dn_valid_o (sq_dn_valid),
    .dn_stall_i (!sm_ld),
    .root_o     (sq_root),
    .tag_o      (sq_tag)
  );

  // ---------------- middle: big component, division operands
  logic signed [NS-1:0]     mn [3];
  logic [2:0]               mneg, mnz;
  logic [NS-1:0]            mmag [3];
  logic [2:0][NW-1:0]       mnum;
  logic [CW-1:0]            bx;
  logic [W-1:0]             mbig;

  always_comb begin
    mn[0] = sq_tag[NS+2:3];
    mn[1] = sq_tag[2*NS+2:NS+3];
    mn[2] = sq_tag[3*NS+2:2*NS+3];
    for (int l = 0; l < 3; l++) begin
      mneg[l]  = mn[l][NS-1];
      mnz[l]   = (mn[l] == '0);
      mmag[l]  = mneg[l] ? NS'(-mn[l]) : NS'(mn[l]);
      mnum[l]  = (NW'(mmag[l]) << F) + NW'(sq_root);
    end
    bx   = (CW'(sq_root) + CW'(1)) >> 1;
    mbig = (bx > CW'(EMAX)) ? EMAX : bx[W-1:0];
  end

  logic               sm_v_r;
  logic [2:0][NW-1:0] sm_n_r;
  logic [DW-1:0]      sm_d_r;
  logic [TAG2-1:0]    sm_tag_r;
  logic               dv_up_stall;

  assign sm_ld = !sm_v_r || !dv_up_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else if (sm_ld) begin
      sm_v_r <= sq_dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sm_ld) begin
      sm_n_r   <= mnum;
      sm_d_r   <= {sq_root, 1'b0};
      sm_tag_r <= {mbig, mneg, mnz, (sq_root == '0), sq_tag[2:0]};
    end
  end

  // ---------------- divider
  hs_t                dv_hs;
  logic               dv_dn_valid;
  logic               so_ld;
  logic [2:0][NW-1:0] dv_q;
  logic [TAG2-1:0]    dv_tag;

  assign dv_hs.valid = sm_v_r;
  assign dv_hs.stall = 1'b0;

  rmq_div #(.NW(NW), .DW(DW), .LANES(3), .TAG_W(TAG2)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_hs_i    (dv_hs),
    .up_stall_o (dv_up_stall),
    .n_i        (sm_n_r),
    .d_i        (sm_d_r),
    .tag_i      (sm_tag_r),
    .dn_valid_o (dv_dn_valid),
    .dn_stall_i (!so_ld),
    .q_o        (dv_q),
    .tag_o      (dv_tag)
  );

  // ---------------- output: saturate, place components
  logic [W-1:0]  obig;
  logic [2:0]    oneg, onz;
  logic          ozero;
  branch_t       obr;
  logic          oflt;
  logic [W-1:0]  oval [3];
  logic [NW-1:0] lim;
  logic [W-1:0]  qw, qx, qy, qz;

  always_comb begin
    obig  = dv_tag[TAG2-1:10];
    oneg  = dv_tag[9:7];
    onz   = dv_tag[6:4];
    ozero = dv_tag[3];
    obr   = branch_t'(dv_tag[2:1]);
    oflt  = dv_tag[0];
    lim   = '0;
    for (int l = 0; l < 3; l++) begin
      lim = NW'(EMAX) + NW'(oneg[l]);
      if (ozero) begin
        oflt    = 1'b1;
        oval[l] = onz[l] ? '0 : (oneg[l] ? EMIN : EMAX);
      end else if (dv_q[l] > lim) begin
        oflt    = 1'b1;
        oval[l] = oneg[l] ? EMIN : EMAX;
      end else begin
        oval[l] = oneg[l] ? W'(-dv_q[l][W-1:0]) : dv_q[l][W-1:0];
      end
    end
    case (obr)
      BR_TRACE: begin qw = obig;    qx = oval[0]; qy = oval[1]; qz = oval[2]; end
      BR_X:     begin qw = oval[0]; qx = obig;    qy = oval[1]; qz = oval[2]; end
      BR_Y:     begin qw = oval[0]; qx = oval[1]; qy = obig;    qz = oval[2]; end
      default:  begin qw = oval[0]; qx = oval[1]; qy = oval[2]; qz = obig;    end
    endcase
  end

  logic            so_v_r;
  logic [W-1:0]    qw_r, qx_r, qy_r, qz_r;
  branch_t         br_r;
  logic            flt_r;

  assign so_ld = !so_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_v_r <= 1'b0;
    end else if (so_ld) begin
      so_v_r <= dv_dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (so_ld) begin
      qw_r  <= qw;
      qx_r  <= qx;
      qy_r  <= qy;
      qz_r  <= qz;
      br_r  <= obr;
      flt_r <= oflt;
    end
  end

  assign out_valid        = so_v_r;
  assign out_quat_w       = qw_r;
  assign out_quat_x       = qx_r;
  assign out_quat_y       = qy_r;
  assign out_quat_z       = qz_r;
  assign out_branch_taken = br_r;
  assign out_fault        = flt_r;

  // ---------------- checks
  a_rst_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_trace_w_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_branch_taken == BR_TRACE) |-> !out_quat_w[W-1])
    else $error("large component negative");

  a_x_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_branch_taken == BR_X) |-> !out_quat_x[W-1])
    else $error("large component negative");

  a_front_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s0_v_r && sq_up_stall |=> s0_v_r && $stable(s0_x_r))
    else $error("front stage lost data under stall");

endmodule

// ===== dv/tb.sv =====
// Testbench for rotation_matrix_to_quaternion: random and directed matrices,
// a built-in fixed-point predictor, and a field-by-field result check.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 1ps
module tb;
  import rmq_pkg::*;

  localparam int FB = 14;
  localparam int EW = 16;
  localparam longint QMAX = 32767;
  localparam longint QMIN = -32768;
  localparam int LATENCY = 51;
  localparam int WDOG_LIMIT = 4000;

  typedef struct {
    logic signed [EW-1:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [EW-1:0] w, x, y, z;
    branch_t br;
    logic fault;
  } quat_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic signed [EW-1:0] in_m [9] = '{default: '0};
  logic signed [EW-1:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  branch_t out_branch_taken;
  logic out_fault;

  matrix_t pending_mats[$];
  quat_t expected_quats[$];
  int errors = 0;
  bit long_hold = 0;
  bit drain_req = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rotation_matrix_to_quaternion u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_branch_taken(out_branch_taken), .out_fault(out_fault)
  );

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // n / (2r), rounded half away from zero, saturated
  function automatic logic signed [EW-1:0] div_by_s(longint n, longint unsigned r,
                                                    ref logic fault);
    longint unsigned mag, q, lim;
    mag = (n < 0) ? -n : n;
    if (r == 0) begin
      fault = 1;
      return (n == 0) ? '0 : (n < 0) ? QMIN[EW-1:0] : QMAX[EW-1:0];
    end
    q = ((mag << FB) + r) / (r << 1);
    lim = (n < 0) ? QMAX + 1 : QMAX;
    if (q > lim) begin
      fault = 1;
      q = lim;
    end
    return (n < 0) ? EW'(-longint'(q)) : EW'(longint'(q));
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t mt);
    longint m [9];
    longint tr, arg, big;
    longint unsigned r;
    logic signed [EW-1:0] bq;
    quat_t q;
    logic f;
    f = 0;
    for (int i = 0; i < 9; i++) m[i] = mt.m[i];
    tr = m[0] + m[4] + m[8];
    if (tr > 0) begin
      q.br = BR_TRACE; arg = (1 << FB) + tr;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      q.br = BR_X; arg = (1 << FB) + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      q.br = BR_Y; arg = (1 << FB) + m[4] - m[0] - m[8];
    end else begin
      q.br = BR_Z; arg = (1 << FB) + m[8] - m[0] - m[4];
    end
    if (arg < 0) begin
      arg = 0; f = 1;
    end
    r = int_sqrt(unsigned'(arg) << FB);
    big = longint'((r + 1) >> 1);
    bq = (big > QMAX) ? QMAX[EW-1:0] : big[EW-1:0];
    case (q.br)
      BR_TRACE: begin
        q.w = bq;
        q.x = div_by_s(m[7] - m[5], r, f);
        q.y = div_by_s(m[2] - m[6], r, f);
        q.z = div_by_s(m[3] - m[1], r, f);
      end
      BR_X: begin
        q.w = div_by_s(m[7] - m[5], r, f);
        q.x = bq;
        q.y = div_by_s(m[1] + m[3], r, f);
        q.z = div_by_s(m[2] + m[6], r, f);
      end
      BR_Y: begin
        q.w = div_by_s(m[2] - m[6], r, f);
        q.x = div_by_s(m[1] + m[3], r, f);
        q.y = bq;
        q.z = div_by_s(m[5] + m[7], r, f);
      end
      default: begin
        q.w = div_by_s(m[3] - m[1], r, f);
        q.x = div_by_s(m[2] + m[6], r, f);
        q.y = div_by_s(m[5] + m[7], r, f);
        q.z = bq;
      end
    endcase
    q.fault = f;
    return q;
  endfunction

  // Driver: bursts of offers with random gaps; hold the payload while stalled.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    matrix_t mt;
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          expected_quats.push_back(matrix_to_quat(pending_mats.pop_front()));
        end
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 0;
        end else if (drain_req && expected_quats.size() != 0) begin
          in_valid <= 0;
        end else if (pending_mats.size() != 0 && !(drain_req && in_valid)) begin
          mt = pending_mats[0];
          for (int i = 0; i < 9; i++) in_m[i] <= mt.m[i];
          in_valid <= 1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(40, 0);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  int stall_mode = 0, mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(3, 0);
      mode_left <= $urandom_range(60, 5);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (long_hold) out_stall <= 1;
    else case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(3, 0) == 0);
      2: out_stall <= ($urandom_range(1, 0) == 0);
      default: out_stall <= ($urandom_range(4, 0) != 0);
    endcase
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    quat_t e;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_quats.size() == 0) begin
          $display("%0t: result with nothing expected: w=%0d x=%0d y=%0d z=%0d",
                   $time, out_quat_w, out_quat_x, out_quat_y, out_quat_z);
          errors++;
        end else begin
          e = expected_quats.pop_front();
          if (out_quat_w !== e.w) begin
            $display("%0t: quat_w expected %0d actual %0d", $time, e.w, out_quat_w);
            errors++;
          end
          if (out_quat_x !== e.x) begin
            $display("%0t: quat_x expected %0d actual %0d", $time, e.x, out_quat_x);
            errors++;
          end
          if (out_quat_y !== e.y) begin
            $display("%0t: quat_y expected %0d actual %0d", $time, e.y, out_quat_y);
            errors++;
          end
          if (out_quat_z !== e.z) begin
            $display("%0t: quat_z expected %0d actual %0d", $time, e.z, out_quat_z);
            errors++;
          end
          if (out_branch_taken !== e.br) begin
            $display("%0t: branch_taken expected %0d actual %0d", $time, e.br,
                     out_branch_taken);
            errors++;
          end
          if (out_fault !== e.fault) begin
            $display("%0t: fault expected %0d actual %0d", $time, e.fault, out_fault);
            errors++;
          end
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [EW-1:0] rand_elem();
    case ($urandom_range(5, 0))
      0: return EW'($urandom);
      1: return EW'($urandom_range(16384, 0) - 8192);
      2: return $urandom_range(3, 0) == 0 ? 16'sh8000 : 16'sh7fff;
      default: return EW'($urandom_range(32768, 0) - 16384);
    endcase
  endfunction

  // Random rotation built from a unit quaternion, plus small noise.
  function automatic matrix_t rand_rotation();
    matrix_t mt;
    real a, b, c, d, n;
    real rm [9];
    a = $urandom_range(2000, 0) - 1000.0;
    b = $urandom_range(2000, 0) - 1000.0;
    c = $urandom_range(2000, 0) - 1000.0;
    d = $urandom_range(2000, 0) - 1000.0;
    n = $sqrt(a*a + b*b + c*c + d*d) + 1e-9;
    a /= n; b /= n; c /= n; d /= n;
    rm[0] = 1 - 2*(c*c + d*d); rm[1] = 2*(b*c - a*d); rm[2] = 2*(b*d + a*c);
    rm[3] = 2*(b*c + a*d); rm[4] = 1 - 2*(b*b + d*d); rm[5] = 2*(c*d - a*b);
    rm[6] = 2*(b*d - a*c); rm[7] = 2*(c*d + a*b); rm[8] = 1 - 2*(b*b + c*c);
    for (int i = 0; i < 9; i++)
      mt.m[i] = EW'($rtoi(rm[i] * 16384.0) + $urandom_range(4, 0) - 2);
    return mt;
  endfunction

  function automatic matrix_t diag_mat(int a, int b, int c);
    matrix_t mt;
    for (int i = 0; i < 9; i++) mt.m[i] = '0;
    mt.m[0] = EW'(a); mt.m[4] = EW'(b); mt.m[8] = EW'(c);
    return mt;
  endfunction

  task automatic wait_drain();
    while (pending_mats.size() != 0 || in_valid || expected_quats.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    matrix_t mt;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: identity, each branch, ties, extremes
    pending_mats.push_back(diag_mat(16384, 16384, 16384));
    pending_mats.push_back(diag_mat(16384, -16384, -16384));
    pending_mats.push_back(diag_mat(-16384, 16384, -16384));
    pending_mats.push_back(diag_mat(-16384, -16384, 16384));
    pending_mats.push_back(diag_mat(-16384, -16384, -16384));
    pending_mats.push_back(diag_mat(0, 0, 0));
    pending_mats.push_back(diag_mat(-5000, -5000, -5000));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768));
    pending_mats.push_back(diag_mat(32767, 32767, 32767));
    pending_mats.push_back(diag_mat(-32768, 32767, 32767));
    pending_mats.push_back(diag_mat(32767, -32768, -32768));
    pending_mats.push_back(diag_mat(-32768, 0, -32768));
    mt = diag_mat(-16384, -16384, -16384);
    mt.m[1] = 16'sd1000; mt.m[2] = -16'sd1000; mt.m[5] = 16'sd3;
    pending_mats.push_back(mt);
    mt = diag_mat(1, 0, 0);
    mt.m[7] = 16'sh7fff; mt.m[5] = 16'sh8000;
    pending_mats.push_back(mt);
    mt = diag_mat(32767, -32768, -32768);
    for (int i = 1; i < 8; i++) if (i != 4) mt.m[i] = (i % 2) ? 16'sh7fff : 16'sh8000;
    pending_mats.push_back(mt);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 9; i++) mt.m[i] = (k % 2) ? 16'sh8000 : 16'sh7fff;
      if (k > 1) for (int i = 0; i < 9; i++) mt.m[i] = ~mt.m[i];
      pending_mats.push_back(mt);
    end
    wait_drain();

    // Long receiver hold-off while items keep coming
    fork
      begin
        long_hold = 1;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
    join_none
    for (int n = 0; n < 120; n++) pending_mats.push_back(rand_rotation());
    wait_drain();

    for (int n = 0; n < 630; n++) begin
      if ($urandom_range(3, 0) == 0) begin
        for (int i = 0; i < 9; i++) mt.m[i] = rand_elem();
      end else begin
        mt = rand_rotation();
      end
      pending_mats.push_back(mt);
      if (n == 300) begin
        // let the queued items go out, then pause the sender until the pipeline is empty
        while (pending_mats.size() != 0) @(posedge clk);
        drain_req = 1;
        wait_drain();
        drain_req = 0;
      end
    end
    wait_drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rmq_pkg.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
dv/tb.sv
